// ===== hw/rtl/opsb_pkg.sv =====
// ----------------------------------------------------------------------------
// opsb_pkg
// Shared constants, control-word types and the microprogram of the OLED
// pixel plotter with shadow display memory.
// ----------------------------------------------------------------------------
package opsb_pkg;

  // Display geometry
  localparam int COLUMNS = 128;
  localparam int ROWS    = 64;
  localparam int PAGES   = (ROWS + 7) / 8;
  localparam int DEPTH   = PAGES * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

  // Fixed field widths
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int BYTE_W = 8;

  // Address command prefixes
  localparam logic [BYTE_W-1:0] COL_LO_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] COL_HI_CMD  = 8'h10;
  localparam logic [BYTE_W-1:0] PAGE_CMD    = 8'hB0;

  localparam logic [BYTE_W-1:0] CONTRAST_RST = 8'hCF;

  // Power-up command list
  localparam int INIT_LEN      = 29;
  localparam int INIT_IDX_W    = $clog2(INIT_LEN);
  localparam int CONTRAST_SLOT = 6;

  localparam logic [BYTE_W-1:0] INIT_LIST [INIT_LEN] = '{
    8'hAE, 8'hAE, 8'h00, 8'h10, 8'h40, 8'h81, 8'hCF, 8'hA1, 8'hC8, 8'hA6,
    8'hA8, 8'h3F, 8'hD3, 8'h00, 8'hD5, 8'h80, 8'hD9, 8'hF1, 8'hDA, 8'h12,
    8'hDB, 8'h40, 8'h20, 8'h02, 8'h8D, 8'h14, 8'hA4, 8'hA6, 8'hAF
  };

  // Input op codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_INIT = 1'b1;

  // Microprogram layout
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_IDLE      = 6'd0;
  localparam logic [STEP_W-1:0] STEP_D0        = 6'd1;
  localparam logic [STEP_W-1:0] STEP_D1        = 6'd2;
  localparam logic [STEP_W-1:0] STEP_D2        = 6'd3;
  localparam logic [STEP_W-1:0] STEP_D3        = 6'd4;
  localparam logic [STEP_W-1:0] STEP_INIT      = 6'd5;
  localparam logic [STEP_W-1:0] STEP_INIT_LAST = STEP_INIT + STEP_W'(INIT_LEN - 1);

  // Output byte source select
  typedef enum logic [2:0] {
    SRC_LIT      = 3'd0,
    SRC_CONTRAST = 3'd1,
    SRC_COL_LO   = 3'd2,
    SRC_COL_HI   = 3'd3,
    SRC_PAGE     = 3'd4,
    SRC_DATA     = 3'd5
  } src_e;

  // Next-step select
  typedef enum logic {
    JMP_NEXT     = 1'b0,
    JMP_DISPATCH = 1'b1
  } jmp_e;

  // One control word
  typedef struct packed {
    logic [BYTE_W-1:0] lit;
    src_e              src;
    logic              emit;
    logic              is_data;
    logic              last;
    logic              mem_wr;
    jmp_e              jmp;
  } ctl_t;

  // Sequencer to datapath
  typedef struct packed {
    ctl_t ctl;
    logic fire;   // current step executes this cycle
    logic load;   // input transaction taken, latch fields
  } cmd_t;

  // Datapath to sequencer
  typedef struct packed {
    logic mem_busy;
    logic out_free;
    logic in_range;
  } stat_t;

  // Microcode ROM
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t                  c;
    logic [INIT_IDX_W-1:0] k;
    c.lit     = '0;
    c.src     = SRC_LIT;
    c.emit    = 1'b0;
    c.is_data = 1'b0;
    c.last    = 1'b0;
    c.mem_wr  = 1'b0;
    c.jmp     = JMP_DISPATCH;
    k         = '0;
    priority if (step == STEP_D0) begin
      c.src  = SRC_COL_LO;
      c.emit = 1'b1;
      c.jmp  = JMP_NEXT;
    end else if (step == STEP_D1) begin
      c.src  = SRC_COL_HI;
      c.emit = 1'b1;
      c.jmp  = JMP_NEXT;
    end else if (step == STEP_D2) begin
      c.src    = SRC_PAGE;
      c.emit   = 1'b1;
      c.mem_wr = 1'b1;
      c.jmp    = JMP_NEXT;
    end else if (step == STEP_D3) begin
      c.src     = SRC_DATA;
      c.emit    = 1'b1;
      c.is_data = 1'b1;
      c.last    = 1'b1;
    end else if (step >= STEP_INIT && step <= STEP_INIT_LAST) begin
      k      = INIT_IDX_W'(step - STEP_INIT);
      c.lit  = INIT_LIST[k];
      c.emit = 1'b1;
      if (k == INIT_IDX_W'(CONTRAST_SLOT)) begin
        c.src = SRC_CONTRAST;
      end
      if (step == STEP_INIT_LAST) begin
        c.last = 1'b1;
      end else begin
        c.jmp = JMP_NEXT;
      end
    end else begin
      // idle step and unused codes: wait for the next transaction
      c.jmp = JMP_DISPATCH;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/oled_pixel_plot_shadow_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// oled_pixel_plot_shadow_buffer_unit
// Pixel plotter and power-up sequencer for a page-addressed OLED controller.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): op_i = 0 draws pixel (x_i, y_i) with
// color_i into the shadow memory; op_i = 1 sends the 29-byte power-up list.
// Output channel (out_valid_o/out_ready_i): one link byte per transaction,
// with is_data_o as the data/command select and last_o on the final byte.
// A draw yields column-low, column-high, page and data bytes; an init yields
// 29 command bytes. Out-of-range draws yield no bytes. The microcode steps
// one control word per cycle unless stalled, and each step emits at most one
// byte through the single output register, so the output port sets the rate:
// the next transaction is accepted on the cycle of the last byte, so draws
// can follow back to back. After acceptance the step register moves to the
// first step, whose byte is then captured in the output register.
// Reset: the contrast register returns to 0xCF and a sweep zeroes all 1024
// shadow bytes, one per cycle; in_ready_o stays low until the sweep ends.
// When the receiver stalls, the byte is held and the sequencer waits.
// cfg_we_i/cfg_wdata_i write contrast; write only while idle.
// ----------------------------------------------------------------------------
module oled_pixel_plot_shadow_buffer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [opsb_pkg::BYTE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [opsb_pkg::X_W-1:0]    x_i,
  input  logic [opsb_pkg::Y_W-1:0]    y_i,
  input  logic                        color_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [opsb_pkg::BYTE_W-1:0] link_byte_o,
  output logic                        is_data_o,
  output logic                        last_o
);
  import opsb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Microcode sequencer
  opsb_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath with shadow memory
  opsb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .color_i     (color_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .link_byte_o (link_byte_o),
    .is_data_o   (is_data_o),
    .last_o      (last_o)
  );

endmodule

// ===== hw/rtl/opsb_shadow_mem.sv =====
// ----------------------------------------------------------------------------
// opsb_shadow_mem
// Shadow display memory, one write and one registered read port, with a
// zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module opsb_shadow_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [opsb_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [opsb_pkg::BYTE_W-1:0]   wdata_i,
  input  logic [opsb_pkg::ADDR_W-1:0]   raddr_i,
  output logic [opsb_pkg::BYTE_W-1:0]   rdata_o,
  output logic                          busy_o
);
  import opsb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              clr_busy_q, clr_busy_d;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;

  // Clear sweep, one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // Write port shared by the sweep and the datapath
  assign wr_en   = clr_busy_q | we_i;
  assign wr_addr = clr_busy_q ? clr_addr_q : waddr_i;
  assign wr_data = clr_busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

// ===== hw/rtl/opsb_datapath.sv =====
// ----------------------------------------------------------------------------
// opsb_datapath
// Input latches, contrast register, pixel read-modify-write, output byte
// select and the output register.
// ----------------------------------------------------------------------------
module opsb_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [opsb_pkg::BYTE_W-1:0] cfg_wdata_i,
  input  logic [opsb_pkg::X_W-1:0]    x_i,
  input  logic [opsb_pkg::Y_W-1:0]    y_i,
  input  logic                        color_i,
  input  opsb_pkg::cmd_t              cmd_i,
  output opsb_pkg::stat_t             stat_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [opsb_pkg::BYTE_W-1:0] link_byte_o,
  output logic                        is_data_o,
  output logic                        last_o
);
  import opsb_pkg::*;

  logic [BYTE_W-1:0] contrast_q;
  logic [X_W-1:0]    x_q;
  logic [PAGE_W-1:0] page_q;
  logic [2:0]        bit_q;
  logic              color_q;
  logic [BYTE_W-1:0] data_q;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q;
  logic              is_data_q;
  logic              last_q;

  logic [ADDR_W-1:0] addr;
  logic [BYTE_W-1:0] rd_byte;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] new_byte;
  logic [BYTE_W-1:0] sel_byte;
  logic              mem_we;
  logic              mem_busy;
  logic              emit;

  // Contrast register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q <= CONTRAST_RST;
    end else if (cfg_we_i) begin
      contrast_q <= cfg_wdata_i;
    end
  end

  // Latch draw coordinates on acceptance
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_i;
      page_q  <= PAGE_W'(y_i >> 3);
      bit_q   <= y_i[2:0];
      color_q <= color_i;
    end
  end

  // Pixel read-modify-write
  assign addr     = ADDR_W'(int'(page_q) * COLUMNS + int'(x_q));
  assign mask     = BYTE_W'(1) << bit_q;
  assign new_byte = color_q ? (rd_byte | mask) : (rd_byte & ~mask);
  assign mem_we   = cmd_i.fire & cmd_i.ctl.mem_wr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      data_q <= new_byte;
    end
  end

  opsb_shadow_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (addr),
    .wdata_i (new_byte),
    .raddr_i (addr),
    .rdata_o (rd_byte),
    .busy_o  (mem_busy)
  );

  // Output byte select
  always_comb begin
    unique case (cmd_i.ctl.src)
      SRC_LIT:      sel_byte = cmd_i.ctl.lit;
      SRC_CONTRAST: sel_byte = contrast_q;
      SRC_COL_LO:   sel_byte = BYTE_W'(x_q) & COL_LO_MASK;
      SRC_COL_HI:   sel_byte = BYTE_W'(x_q >> 4) | COL_HI_CMD;
      SRC_PAGE:     sel_byte = BYTE_W'(page_q) | PAGE_CMD;
      SRC_DATA:     sel_byte = data_q;
      default:      sel_byte = cmd_i.ctl.lit;
    endcase
  end

  // Output register
  assign emit = cmd_i.fire & cmd_i.ctl.emit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q    <= sel_byte;
      is_data_q <= cmd_i.ctl.is_data;
      last_q    <= cmd_i.ctl.last;
    end
  end

  // Status back to the sequencer
  assign stat_o.mem_busy = mem_busy;
  assign stat_o.out_free = ~out_valid_q | out_ready_i;
  assign stat_o.in_range = (int'(x_i) < COLUMNS) && (int'(y_i) < ROWS);

  assign out_valid_o = out_valid_q;
  assign link_byte_o = byte_q;
  assign is_data_o   = is_data_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/opsb_sequencer.sv =====
// ----------------------------------------------------------------------------
// opsb_sequencer
// Step counter over the microcode ROM; dispatches new transactions and
// stalls on the output register or the memory clear sweep.
// ----------------------------------------------------------------------------
module opsb_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            op_i,
  input  opsb_pkg::stat_t stat_i,
  output opsb_pkg::cmd_t  cmd_o
);
  import opsb_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  ctl_t              ctl;
  logic              go;
  logic              accept;

  assign ctl = ucode(step_q);

  // A step runs when the memory is ready and its byte has a place to go
  assign go         = ~stat_i.mem_busy & (~ctl.emit | stat_i.out_free);
  assign in_ready_o = go & (ctl.jmp == JMP_DISPATCH);
  assign accept     = in_ready_o & in_valid_i;

  // Next step
  always_comb begin
    step_d = step_q;
    if (go) begin
      unique case (ctl.jmp)
        JMP_NEXT: step_d = step_q + 1'b1;
        JMP_DISPATCH: begin
          priority if (!accept) begin
            step_d = STEP_IDLE;
          end else if (op_i == OP_INIT) begin
            step_d = STEP_INIT;
          end else if (stat_i.in_range) begin
            step_d = STEP_D0;
          end else begin
            step_d = STEP_IDLE;
          end
        end
        default: step_d = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign cmd_o.ctl  = ctl;
  assign cmd_o.fire = go;
  assign cmd_o.load = accept;

endmodule

// ===== hw/rtl/opsb_checker.sv =====
// ----------------------------------------------------------------------------
// opsb_checker
// Port-level checks for the OLED pixel plotter, bound to the top level.
// ----------------------------------------------------------------------------
module opsb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [opsb_pkg::BYTE_W-1:0] cfg_wdata_i,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        op_i,
  input logic [opsb_pkg::X_W-1:0]    x_i,
  input logic [opsb_pkg::Y_W-1:0]    y_i,
  input logic                        color_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [opsb_pkg::BYTE_W-1:0] link_byte_o,
  input logic                        is_data_o,
  input logic                        last_o
);
  import opsb_pkg::*;

  // Stalled byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(link_byte_o)
      && $stable(is_data_o) && $stable(last_o))
    else $error("output byte changed under stall");

  // A taken transaction keeps the sequencer busy in the following cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on two consecutive cycles");

  // Only the pixel data byte is display data, and it always closes a draw
  a_data_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_data_o |-> last_o)
    else $error("data byte without last");

  // A closing command byte is the final power-up command
  a_init_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !is_data_o |-> link_byte_o == INIT_LIST[INIT_LEN-1])
    else $error("wrong final command byte");

  // Clear sweep blocks input right after reset
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |=> !in_ready_o)
    else $error("input ready during memory clear");

endmodule

bind oled_pixel_plot_shadow_buffer_unit opsb_checker u_opsb_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the OLED pixel plotter with shadow display memory.
// A queue-fed driver sends draw and power-up transactions, a scoreboard
// predicts every link byte from its own copy of the shadow memory and of the
// contrast register, and a monitor compares each output byte in order.
// Traffic runs in four phases with different sender gaps and receiver stalls.
// The contrast register is rewritten between phases, and only while idle.
// ----------------------------------------------------------------------------
module testbench;

  import opsb_pkg::*;

  // Bench constants
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          RANDOM_PER_PH  = 50;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          POWERUP_LEN    = 29;
  localparam int          CONTRAST_POS   = 6;
  localparam logic [7:0]  NIBBLE_MASK    = 8'h0F;
  localparam logic [7:0]  SET_COL_HI     = 8'h10;
  localparam logic [7:0]  SET_PAGE       = 8'hB0;
  localparam logic [7:0]  CONTRAST_RESET = 8'hCF;

  // Power-up command list as sent on the link; the contrast slot is replaced
  localparam logic [7:0] POWERUP_CMDS [POWERUP_LEN] = '{
    8'hAE, 8'hAE, 8'h00, 8'h10, 8'h40, 8'h81, 8'hCF, 8'hA1, 8'hC8, 8'hA6,
    8'hA8, 8'h3F, 8'hD3, 8'h00, 8'hD5, 8'h80, 8'hD9, 8'hF1, 8'hDA, 8'h12,
    8'hDB, 8'h40, 8'h20, 8'h02, 8'h8D, 8'h14, 8'hA4, 8'hA6, 8'hAF
  };

  typedef enum int {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_GAPS
  } traffic_e;

  typedef struct packed {
    logic           op;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           color;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_data;
    logic       last;
  } link_byte_t;

  // DUT signals; the inputs are at known values from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [BYTE_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              op_i        = OP_DRAW;
  logic [X_W-1:0]    x_i         = '0;
  logic [Y_W-1:0]    y_i         = '0;
  logic              color_i     = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BYTE_W-1:0] link_byte_o;
  logic              is_data_o;
  logic              last_o;

  // Bench state
  pixel_cmd_t  pixel_cmds_q[$];
  link_byte_t  link_bytes_due[$];
  logic [7:0]  pixel_shadow [PAGES][COLUMNS];
  logic [7:0]  contrast_copy = CONTRAST_RESET;
  traffic_e    traffic_phase = PH_STEADY;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  oled_pixel_plot_shadow_buffer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .color_i     (color_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .link_byte_o (link_byte_o),
    .is_data_o   (is_data_o),
    .last_o      (last_o)
  );

  // Clock
  always #5 clk_i = ~clk_i;

  // Link bytes caused by one transaction; updates the shadow copy on draws
  function automatic void predict_link_bytes(pixel_cmd_t cmd);
    int unsigned page;
    logic [7:0]  mask;
    logic [7:0]  pix_byte;
    if (cmd.op == OP_INIT) begin
      for (int i = 0; i < POWERUP_LEN; i++) begin
        link_bytes_due.push_back('{
          link_byte: (i == CONTRAST_POS) ? contrast_copy : POWERUP_CMDS[i],
          is_data:   1'b0,
          last:      (i == POWERUP_LEN - 1)});
      end
      return;
    end
    // off-panel coordinates are dropped without a byte
    if (int'(cmd.x) >= COLUMNS || int'(cmd.y) >= ROWS) return;
    page     = cmd.y >> 3;
    mask     = 8'h01 << cmd.y[2:0];
    pix_byte = pixel_shadow[page][cmd.x];
    pix_byte = cmd.color ? (pix_byte | mask) : (pix_byte & ~mask);
    pixel_shadow[page][cmd.x] = pix_byte;
    link_bytes_due.push_back('{8'(cmd.x) & NIBBLE_MASK, 1'b0, 1'b0});
    link_bytes_due.push_back('{8'(cmd.x >> 4) | SET_COL_HI, 1'b0, 1'b0});
    link_bytes_due.push_back('{8'(page) | SET_PAGE, 1'b0, 1'b0});
    link_bytes_due.push_back('{pix_byte, 1'b1, 1'b1});
  endfunction

  function automatic bit sender_gap();
    case (traffic_phase)
      PH_SEND_GAPS: return $urandom_range(99) < 60;
      PH_BOTH_GAPS: return $urandom_range(99) < 32;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (traffic_phase)
      PH_RECV_STALLS: return $urandom_range(99) < 60;
      PH_BOTH_GAPS:   return $urandom_range(99) < 32;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic void queue_cmd(logic op, int x, int y, logic color);
    pixel_cmds_q.push_back('{op, X_W'(x), Y_W'(y), color});
  endfunction

  // Mostly draws, clustered on a few columns half the time so bytes get
  // read-modify-written repeatedly; a few power-up transactions mixed in
  function automatic void queue_random_cmds(int count);
    int x;
    for (int i = 0; i < count; i++) begin
      x = ($urandom_range(1) != 0) ? $urandom_range(15) : $urandom_range(127);
      queue_cmd(($urandom_range(99) < 6) ? OP_INIT : OP_DRAW, x,
                $urandom_range(63), 1'($urandom_range(1)));
    end
  endfunction

  // Driver: presents queued transactions, holds each until accepted
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_link_bytes('{op_i, x_i, y_i, color_i});
    end
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && pixel_cmds_q.size() > 0 && !sender_gap()) begin
        pixel_cmd_t cmd;
        cmd        = pixel_cmds_q.pop_front();
        op_i       <= cmd.op;
        x_i        <= cmd.x;
        y_i        <= cmd.y;
        color_i    <= cmd.color;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each link byte against the oldest prediction
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (link_bytes_due.size() == 0) begin
        $error("unexpected link byte 0x%02h", link_byte_o);
        error_count++;
      end else begin
        link_byte_t exp_byte;
        exp_byte = link_bytes_due.pop_front();
        if (link_byte_o !== exp_byte.link_byte) begin
          $error("link_byte: expected 0x%02h, got 0x%02h", exp_byte.link_byte,
                 link_byte_o);
          error_count++;
        end
        if (is_data_o !== exp_byte.is_data) begin
          $error("is_data: expected %0b, got %0b", exp_byte.is_data, is_data_o);
          error_count++;
        end
        if (last_o !== exp_byte.last) begin
          $error("last: expected %0b, got %0b", exp_byte.last, last_o);
          error_count++;
        end
      end
    end
    out_ready_i <= rst_ni && !receiver_stall();
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL oled_pixel_plot_shadow_buffer_unit");
      $finish;
    end
  end

  // Block until every queued transaction went in and every byte came out
  task automatic wait_drained();
    @(negedge clk_i);
    while (pixel_cmds_q.size() != 0 || in_valid_i || link_bytes_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_contrast(logic [7:0] value);
    @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    contrast_copy = value;
    @(negedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    foreach (pixel_shadow[p, c]) pixel_shadow[p][c] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: power-up with reset contrast, panel corners, bit patterns,
    // set/clear on one byte, clearing a blank pixel, ignored fields on init
    queue_cmd(OP_INIT, 0, 0, 1'b0);
    queue_cmd(OP_DRAW, 0, 0, 1'b1);
    queue_cmd(OP_DRAW, 127, 63, 1'b1);
    queue_cmd(OP_DRAW, 127, 0, 1'b1);
    queue_cmd(OP_DRAW, 0, 63, 1'b1);
    queue_cmd(OP_DRAW, 0, 0, 1'b0);
    queue_cmd(OP_DRAW, 0, 0, 1'b0);
    queue_cmd(OP_DRAW, 85, 42, 1'b1);
    queue_cmd(OP_DRAW, 42, 21, 1'b1);
    queue_cmd(OP_DRAW, 99, 37, 1'b0);
    for (int r = 8; r < 16; r++) queue_cmd(OP_DRAW, 5, r, 1'b1);
    queue_cmd(OP_DRAW, 5, 11, 1'b0);
    queue_cmd(OP_DRAW, 5, 15, 1'b0);
    queue_cmd(OP_DRAW, 5, 11, 1'b1);
    queue_cmd(OP_INIT, 127, 63, 1'b1);
    queue_random_cmds(RANDOM_PER_PH);
    wait_drained();

    // Contrast at both extremes and a random value, one per traffic phase
    write_contrast(8'h00);
    traffic_phase = PH_SEND_GAPS;
    queue_cmd(OP_INIT, $urandom_range(127), $urandom_range(63), 1'($urandom_range(1)));
    queue_random_cmds(RANDOM_PER_PH);
    wait_drained();

    write_contrast(8'hFF);
    traffic_phase = PH_RECV_STALLS;
    queue_cmd(OP_INIT, $urandom_range(127), $urandom_range(63), 1'($urandom_range(1)));
    queue_random_cmds(RANDOM_PER_PH);
    wait_drained();

    write_contrast(8'($urandom_range(255)));
    traffic_phase = PH_BOTH_GAPS;
    queue_cmd(OP_INIT, $urandom_range(127), $urandom_range(63), 1'($urandom_range(1)));
    queue_random_cmds(RANDOM_PER_PH);
    wait_drained();

    if (error_count == 0) begin
      $display("PASS oled_pixel_plot_shadow_buffer_unit");
    end else begin
      $display("FAIL oled_pixel_plot_shadow_buffer_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/opsb_pkg.sv
hw/rtl/opsb_shadow_mem.sv
hw/rtl/opsb_datapath.sv
hw/rtl/opsb_sequencer.sv
hw/rtl/oled_pixel_plot_shadow_buffer_unit.sv
hw/rtl/opsb_checker.sv
sim/testbench.sv
